/* rtl/core/swrs_pkg.sv */
// ============================================================================
// swrs_pkg: shared types, constants and microprogram
// Control word format, operation and condition codes, and the read-only
// program that sequences the sliding window rate statistics datapath.
// ============================================================================
package swrs_pkg;

    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 64;
    localparam int PC_W    = 4;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_TAKE     = 4'd1,
        OP_SCAN     = 4'd2,
        OP_DRAIN    = 4'd3,
        OP_DIV_W    = 4'd4,
        OP_DIV_STEP = 4'd5,
        OP_SAVE_W   = 4'd6,
        OP_DIV_S    = 4'd7,
        OP_SAVE_S   = 4'd8,
        OP_EMIT     = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NO_INPUT   = 3'd2,
        C_SCAN_MORE  = 3'd3,
        C_DIV_MORE   = 3'd4,
        C_NO_SETTLED = 3'd5,
        C_OUT_BUSY   = 3'd6
    } cond_t;

    localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] S_SCAN   = 4'd1;
    localparam logic [PC_W-1:0] S_DRAIN  = 4'd2;
    localparam logic [PC_W-1:0] S_DIV_W  = 4'd3;
    localparam logic [PC_W-1:0] S_STEP_W = 4'd4;
    localparam logic [PC_W-1:0] S_SAVE_W = 4'd5;
    localparam logic [PC_W-1:0] S_DIV_S  = 4'd6;
    localparam logic [PC_W-1:0] S_STEP_S = 4'd7;
    localparam logic [PC_W-1:0] S_SAVE_S = 4'd8;
    localparam logic [PC_W-1:0] S_EMIT   = 4'd9;
    localparam logic [PC_W-1:0] S_RETURN = 4'd10;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic no_input;
        logic scan_more;
        logic div_more;
        logic no_settled;
        logic out_busy;
    } seq_status_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            S_IDLE:   w = '{op: OP_TAKE,     cond: C_NO_INPUT,   target: S_IDLE};
            S_SCAN:   w = '{op: OP_SCAN,     cond: C_SCAN_MORE,  target: S_SCAN};
            S_DRAIN:  w = '{op: OP_DRAIN,    cond: C_NEVER,      target: S_IDLE};
            S_DIV_W:  w = '{op: OP_DIV_W,    cond: C_NEVER,      target: S_IDLE};
            S_STEP_W: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: S_STEP_W};
            S_SAVE_W: w = '{op: OP_SAVE_W,   cond: C_NEVER,      target: S_IDLE};
            S_DIV_S:  w = '{op: OP_DIV_S,    cond: C_NO_SETTLED, target: S_SAVE_S};
            S_STEP_S: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: S_STEP_S};
            S_SAVE_S: w = '{op: OP_SAVE_S,   cond: C_NEVER,      target: S_IDLE};
            S_EMIT:   w = '{op: OP_EMIT,     cond: C_OUT_BUSY,   target: S_EMIT};
            S_RETURN: w = '{op: OP_NONE,     cond: C_ALWAYS,     target: S_IDLE};
            default:  w = '{op: OP_NONE,     cond: C_ALWAYS,     target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/swrs_ram.sv */
// ============================================================================
// swrs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module swrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/swrs_div.sv */
// ============================================================================
// swrs_div: iterative restoring divider
// Divides a 64-bit dividend by a 32-bit divisor one quotient bit per cycle
// while ctrl.step is held, for operands whose quotient is known to fit in 32 bits.
// ============================================================================
module swrs_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  swrs_pkg::div_ctrl_t                  ctrl,
    input  logic [swrs_pkg::TOTAL_W-1:0]         dividend,
    input  logic [swrs_pkg::DATA_W-1:0]          divisor,
    output logic [swrs_pkg::DATA_W-1:0]          quotient,
    output logic                                 last
);
    import swrs_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DATA_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            rem_next = dividend[TOTAL_W-1:DATA_W];
            quo_next = dividend[DATA_W-1:0];
            dsr_next = divisor;
            cnt_next = '0;
        end else if (ctrl.step) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
            end else begin
                rem_next = shifted[DATA_W-1:0];
            end
            quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == {CNT_W{1'b1}});

endmodule

/* rtl/core/swrs_seq.sv */
// ============================================================================
// swrs_seq: microcode sequencer
// Step counter over the read-only program, with conditional jumps on
// datapath status.
// ============================================================================
module swrs_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swrs_pkg::seq_status_t status,
    output swrs_pkg::op_t         op
);
    import swrs_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          word;
    logic            taken;

    always_comb begin
        word = ucode_rom(pc_reg);
        unique case (word.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_INPUT:   taken = status.no_input;
            C_SCAN_MORE:  taken = status.scan_more;
            C_DIV_MORE:   taken = status.div_more;
            C_NO_SETTLED: taken = status.no_settled;
            C_OUT_BUSY:   taken = status.out_busy;
            default:      taken = 1'b1;
        endcase
        pc_next = taken ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign op = word.op;

endmodule

/* rtl/core/sliding_window_rate_statistics_unit.sv */
// ============================================================================
// sliding_window_rate_statistics_unit: windowed and long-run rate statistics
// Keeps the last WINDOW samples and reports their rounded mean, minimum and
// maximum, together with a saturating long-run mean and sample count.
// ============================================================================
// One sample is taken at a time. The window of held samples (at most WINDOW)
// is read back one entry per cycle from its RAM, and each mean is then formed
// in the shared one-bit-per-cycle divider; the long-run division steps are
// skipped while no sample has yet entered the long-run mean. A finished result
// waits in the output register, and the next sample is accepted while it
// waits. No clearing pass is needed after reset.
module sliding_window_rate_statistics_unit #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] sample
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] window_mean, [63:32] window_min, [95:64] window_max,
    // [127:96] settled_mean, [159:128] settled_count
    output logic [159:0] m_tdata
);
    import swrs_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;

    op_t               op;
    seq_status_t       status;
    div_ctrl_t         div_ctrl;

    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [DATA_W-1:0]      count_reg, count_next;
    logic [DATA_W-1:0]      wmean_reg, wmean_next;
    logic [DATA_W-1:0]      smean_reg, smean_next;
    logic                   m_valid_reg, m_valid_next;
    logic [159:0]           m_data_reg, m_data_next;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   out_busy;
    logic [TOTAL_W-1:0]     div_dividend;
    logic [DATA_W-1:0]      div_divisor;
    logic [DATA_W-1:0]      quotient;
    logic                   div_last;

    swrs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    swrs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (accept),
        .waddr (slot_reg),
        .wdata (sample),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (rd_data)
    );

    swrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    assign s_tready = (op == OP_TAKE);
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign out_busy = m_valid_reg && !m_tready;

    always_comb begin
        status.no_input   = !s_tvalid;
        status.scan_more  = ((CNT_W + 1)'(idx_reg) + 1'b1) < (CNT_W + 1)'(filled_reg);
        status.div_more   = !div_last;
        status.no_settled = (count_reg == '0);
        status.out_busy   = out_busy;

        div_ctrl.load = (op == OP_DIV_W) || (op == OP_DIV_S);
        div_ctrl.step = (op == OP_DIV_STEP);

        if (op == OP_DIV_S) begin
            div_dividend = total_reg + TOTAL_W'(count_reg >> 1);
            div_divisor  = count_reg;
        end else begin
            div_dividend = TOTAL_W'(sum_reg) + TOTAL_W'(filled_reg >> 1);
            div_divisor  = DATA_W'(filled_reg);
        end
    end

    always_comb begin
        slot_next    = slot_reg;
        filled_next  = filled_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        sum_next     = sum_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        wmean_next   = wmean_reg;
        smean_next   = smean_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        // The read issued in the previous cycle lands now.
        if (((op == OP_SCAN) || (op == OP_DRAIN)) && pend_reg) begin
            sum_next = sum_reg + SUM_W'(rd_data);
            if (rd_data < min_reg) begin
                min_next = rd_data;
            end
            if (rd_data > max_reg) begin
                max_next = rd_data;
            end
        end

        unique case (op)
            OP_TAKE: begin
                if (accept) begin
                    slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    // The held-sample count and the warm-up count move together.
                    if (filled_reg != CNT_W'(WINDOW)) begin
                        filled_next = filled_reg + 1'b1;
                    end
                    if ((filled_next == CNT_W'(WINDOW)) && (count_reg != '1)) begin
                        total_next = total_reg + TOTAL_W'(sample);
                        count_next = count_reg + 1'b1;
                    end
                    idx_next  = '0;
                    pend_next = 1'b0;
                    sum_next  = '0;
                    min_next  = '1;
                    max_next  = '0;
                end
            end
            OP_SCAN: begin
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end
            OP_DRAIN: begin
                pend_next = 1'b0;
            end
            OP_SAVE_W: begin
                wmean_next = quotient;
            end
            OP_SAVE_S: begin
                smean_next = (count_reg == '0) ? wmean_reg : quotient;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {count_reg, smean_reg, DATA_W'(max_reg),
                                    DATA_W'(min_reg), wmean_reg};
                end
            end
            OP_NONE, OP_DIV_W, OP_DIV_S, OP_DIV_STEP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            filled_reg  <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            total_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            slot_reg    <= slot_next;
            filled_reg  <= filled_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        sum_reg    <= sum_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        wmean_reg  <= wmean_next;
        smean_reg  <= smean_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for sliding_window_rate_statistics_unit
// Streams rate samples into the unit under random burst and stall patterns,
// predicts the window mean, minimum, maximum and the long-run mean and count
// for every accepted sample, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swrs_pkg::DATA_W;
    import swrs_pkg::TOTAL_W;

    localparam int WINDOW       = 20;
    localparam int SAMPLE_BITS  = 32;
    localparam int RANDOM_ITEMS = 1350;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int LONG_HOLD    = 600;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [DATA_W-1:0] settled_count;
        logic [DATA_W-1:0] settled_mean;
        logic [DATA_W-1:0] window_max;
        logic [DATA_W-1:0] window_min;
        logic [DATA_W-1:0] window_mean;
    } rate_stats_t;

    class rate_scoreboard;
        logic [DATA_W-1:0]  ring [WINDOW];
        int unsigned        next_slot;
        int unsigned        held;
        int unsigned        warmup;
        logic [TOTAL_W-1:0] longrun_total;
        logic [DATA_W-1:0]  longrun_count;
        rate_stats_t        pending_stats [$];
        int                 failures;

        function new();
            next_slot     = 0;
            held          = 0;
            warmup        = 0;
            longrun_total = '0;
            longrun_count = '0;
            failures      = 0;
        endfunction

        function void note_sample(logic [DATA_W-1:0] raw);
            logic [DATA_W-1:0]  s;
            logic [TOTAL_W-1:0] sum;
            rate_stats_t        r;
            s   = raw & DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);
            ring[next_slot] = s;
            next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
            if (held < WINDOW) held++;
            sum          = '0;
            r.window_min = '1;
            r.window_max = '0;
            for (int i = 0; i < held; i++) begin
                sum += TOTAL_W'(ring[i]);
                if (ring[i] < r.window_min) r.window_min = ring[i];
                if (ring[i] > r.window_max) r.window_max = ring[i];
            end
            r.window_mean = DATA_W'((sum + TOTAL_W'(held / 2)) / TOTAL_W'(held));
            if (warmup < WINDOW) warmup++;
            if (warmup >= WINDOW && longrun_count != '1) begin
                longrun_total += TOTAL_W'(s);
                longrun_count++;
            end
            if (longrun_count != '0) begin
                r.settled_mean = DATA_W'((longrun_total + TOTAL_W'(longrun_count / 2))
                                         / TOTAL_W'(longrun_count));
            end else begin
                r.settled_mean = r.window_mean;
            end
            r.settled_count = longrun_count;
            pending_stats.push_back(r);
        endfunction

        function void fault(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            failures++;
            if (failures <= REPORT_MAX)
                $display("MISMATCH %s: expected %h actual %h", what, want, got);
        endfunction

        function void compare(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (want !== got) fault(what, want, got);
        endfunction

        function void check_result(logic [5*DATA_W-1:0] beat);
            rate_stats_t got;
            rate_stats_t want;
            got = beat;
            if (pending_stats.size() == 0) begin
                fault("unexpected result beat, window_mean", '0, got.window_mean);
                return;
            end
            want = pending_stats.pop_front();
            compare("window_mean", want.window_mean, got.window_mean);
            compare("window_min", want.window_min, got.window_min);
            compare("window_max", want.window_max, got.window_max);
            compare("settled_mean", want.settled_mean, got.settled_mean);
            compare("settled_count", want.settled_count, got.settled_count);
        endfunction

        function int outstanding();
            return pending_stats.size();
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [5*DATA_W-1:0] m_tdata;

    rate_scoreboard sb = new();

    logic              steady_flow = 1'b0;
    int unsigned       hold_requests = 0;
    int unsigned       burst_left = 0;
    int unsigned       regime = 0;
    int unsigned       regime_left = 0;
    logic [DATA_W-1:0] base_rate = '0;
    int unsigned       jitter = 0;
    int unsigned       cycles = 0;

    logic [DATA_W-1:0] directed_samples [24] = '{
        32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002
    };

    sliding_window_rate_statistics_unit #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("sliding_window_rate_statistics_unit test failed");
            $finish;
        end
    end

    task automatic idle_cycles(input int unsigned n);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] v);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(v);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            if (!steady_flow) begin
                if ($urandom_range(0, 5) == 0)
                    idle_cycles($urandom_range(40, 160));
                else
                    idle_cycles($urandom_range(1, 30));
            end
        end
    endtask

    task automatic wait_all_results();
        idle_cycles(1);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_sample();
        if (regime_left == 0) begin
            regime      = $urandom_range(0, 5);
            regime_left = $urandom_range(5, 60);
            base_rate   = $urandom;
            jitter      = $urandom_range(0, 24);
        end
        regime_left--;
        case (regime)
            0: return base_rate + DATA_W'($urandom_range(0, (1 << jitter) - 1));
            1: return $urandom;
            2: return DATA_W'($urandom_range(0, 15));
            3: return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 15));
            4: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return base_rate;
        endcase
    endfunction

    initial begin
        int unsigned hold_left;
        int unsigned holds_done;
        int unsigned run_left;
        logic        ready_level;
        hold_left   = 0;
        holds_done  = 0;
        run_left    = 0;
        ready_level = 1'b1;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (steady_flow) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    ready_level = ($urandom_range(0, 2) != 0);
                    run_left    = ready_level ? $urandom_range(1, 40)
                                              : $urandom_range(1, 25);
                end
                run_left--;
                m_tready <= ready_level;
            end
            @(posedge aclk);
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_samples[i]) send_sample(directed_samples[i]);
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) steady_flow <= 1'b1;
            if (n == 450) steady_flow <= 1'b0;
            if (n == 700) hold_requests <= hold_requests + 1;
            if (n == 900) wait_all_results();
            send_sample(pick_sample());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("sliding_window_rate_statistics_unit test passed");
        end else begin
            $display("sliding_window_rate_statistics_unit test failed");
        end
        $finish;
    end
endmodule
